// ----- src/dats_pkg.sv -----
// ----------------------------------------------------------------------------
// dats_pkg
// Shared types and constants for the DNS answer TTL scanner.
// ----------------------------------------------------------------------------
package dats_pkg;

  localparam int unsigned HeaderLen = 12;
  localparam logic [7:0]  PtrMark   = 8'd128;
  localparam logic [15:0] FixedQ    = 16'd4;
  localparam logic [15:0] FixedPtr  = 16'd5;
  localparam int unsigned MaxRes    = 4;

  localparam logic [3:0] HdrQdHi = 4'd4;
  localparam logic [3:0] HdrQdLo = 4'd5;
  localparam logic [3:0] HdrAnHi = 4'd6;
  localparam logic [3:0] HdrAnLo = 4'd7;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_NAME,
    PH_LABEL,
    PH_FIXED,
    PH_TTL,
    PH_RDHI,
    PH_RDLO,
    PH_RDATA,
    PH_PASS
  } phase_t;

endpackage

// ----- src/dns_answer_ttl_scanner.sv -----
// ----------------------------------------------------------------------------
// dns_answer_ttl_scanner
// Parses a DNS message byte by byte, tracks the minimum answer TTL or
// rewrites each answer TTL as TTL minus delta.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   input   | in_valid, in_ready  | data_byte, msg_last, func, delta
//   output  | out_valid, out_ready| out_byte, run_last, msg_end, min_ttl,
//           |                     | truncated
//
// A byte is parsed in the cycle it is accepted; its results (zero to four
// beats) sit in a four-byte output buffer and leave one beat per cycle
// while out_ready is high. Most bytes give one beat, so the sustained rate
// is one byte per cycle without stalls; the fourth byte of a rewritten TTL
// gives four beats and holds input. A new byte is taken while the last
// buffered beat is being taken. Reset clears the parser and the buffer.
// ----------------------------------------------------------------------------
module dns_answer_ttl_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        msg_last,
  input  logic        func,
  input  logic [31:0] delta,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        msg_end,
  output logic [31:0] min_ttl,
  output logic        truncated
);

  // parser state
  dats_pkg::phase_t phase, phase_next;
  logic [3:0]  hdr_idx, hdr_idx_next;
  logic [15:0] q_left, q_left_next;
  logic [15:0] a_left, a_left_next;
  logic [15:0] skip, skip_next;
  logic [23:0] held, held_next;
  logic [1:0]  ttl_idx, ttl_idx_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [31:0] run_min, run_min_next;
  logic        mode, mode_next;
  logic [31:0] dlt, dlt_next;
  logic        at_start, at_start_next;

  // output buffer
  logic [31:0] obuf;
  logic [2:0]  cnt;
  logic [31:0] grp_min;
  logic        grp_end;
  logic        grp_trunc;

  logic        accept;
  logic        pop;
  logic [2:0]  n_res;
  logic [31:0] res_bytes;
  logic [31:0] ttl_full;
  logic [31:0] ttl_new;

  assign out_valid = (cnt != 3'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);
  assign accept    = in_valid && in_ready;

  assign out_byte  = obuf[31:24];
  assign run_last  = (cnt == 3'd1);
  assign msg_end   = (cnt == 3'd1) && grp_end;
  assign truncated = (cnt == 3'd1) && grp_trunc;
  assign min_ttl   = grp_min;

  always_comb begin
    dats_pkg::phase_t ph;
    logic [3:0]  hi;
    logic [15:0] ql;
    logic [15:0] al;
    logic [15:0] sk;
    logic [23:0] hd;
    logic [1:0]  ti;
    logic [7:0]  lh;
    logic [31:0] rm;
    logic        md;
    logic [31:0] dl;
    logic [3:0]  hi_inc;
    logic [15:0] sk_dec;
    logic [15:0] al_dec;
    logic [15:0] rdlen;

    if (at_start) begin
      ph = dats_pkg::PH_HDR;
      hi = 4'd0;
      ql = 16'd0;
      al = 16'd0;
      sk = 16'd0;
      hd = 24'd0;
      ti = 2'd0;
      lh = 8'd0;
      rm = '1;
      md = func;
      dl = delta;
    end else begin
      ph = phase;
      hi = hdr_idx;
      ql = q_left;
      al = a_left;
      sk = skip;
      hd = held;
      ti = ttl_idx;
      lh = len_hi;
      rm = run_min;
      md = mode;
      dl = dlt;
    end

    hi_inc   = hi + 4'd1;
    sk_dec   = sk - 16'd1;
    al_dec   = al - 16'd1;
    rdlen    = {lh, data_byte};
    ttl_full = {hd, data_byte};
    ttl_new  = ttl_full - dl;

    phase_next   = ph;
    hdr_idx_next = hi;
    q_left_next  = ql;
    a_left_next  = al;
    skip_next    = sk;
    held_next    = hd;
    ttl_idx_next = ti;
    len_hi_next  = lh;
    run_min_next = rm;
    mode_next    = md;
    dlt_next     = dl;
    n_res        = 3'd1;
    res_bytes    = {data_byte, 24'd0};

    case (ph)
      dats_pkg::PH_HDR: begin
        case (hi)
          dats_pkg::HdrQdHi: q_left_next = {data_byte, ql[7:0]};
          dats_pkg::HdrQdLo: q_left_next = {ql[15:8], data_byte};
          dats_pkg::HdrAnHi: a_left_next = {data_byte, al[7:0]};
          dats_pkg::HdrAnLo: a_left_next = {al[15:8], data_byte};
          default: ;
        endcase
        hdr_idx_next = hi_inc;
        if (hi_inc >= 4'(dats_pkg::HeaderLen)) begin
          phase_next = (ql != 16'd0 || al != 16'd0) ? dats_pkg::PH_NAME
                                                    : dats_pkg::PH_PASS;
        end
      end
      dats_pkg::PH_NAME: begin
        if (data_byte == 8'd0) begin
          skip_next  = dats_pkg::FixedQ;
          phase_next = dats_pkg::PH_FIXED;
        end else if (data_byte >= dats_pkg::PtrMark) begin
          skip_next  = dats_pkg::FixedPtr;
          phase_next = dats_pkg::PH_FIXED;
        end else begin
          skip_next  = {8'd0, data_byte};
          phase_next = dats_pkg::PH_LABEL;
        end
      end
      dats_pkg::PH_LABEL: begin
        skip_next = sk_dec;
        if (sk_dec == 16'd0) phase_next = dats_pkg::PH_NAME;
      end
      dats_pkg::PH_FIXED: begin
        skip_next = sk_dec;
        if (sk_dec == 16'd0) begin
          if (ql != 16'd0) begin
            q_left_next = ql - 16'd1;
            phase_next  = ((ql - 16'd1) != 16'd0 || al != 16'd0) ? dats_pkg::PH_NAME
                                                                  : dats_pkg::PH_PASS;
          end else begin
            ttl_idx_next = 2'd0;
            held_next    = 24'd0;
            phase_next   = dats_pkg::PH_TTL;
          end
        end
      end
      dats_pkg::PH_TTL: begin
        if (ti == 2'd3) begin
          if (md) begin
            n_res     = 3'(dats_pkg::MaxRes);
            res_bytes = ttl_new;
          end else if (ttl_full < rm) begin
            run_min_next = ttl_full;
          end
          ttl_idx_next = 2'd0;
          phase_next   = dats_pkg::PH_RDHI;
        end else begin
          if (md) begin
            if (msg_last) begin
              n_res = {1'b0, ti} + 3'd1;
              case (ti)
                2'd1:    res_bytes = {hd[7:0], data_byte, 16'd0};
                2'd2:    res_bytes = {hd[15:0], data_byte, 8'd0};
                default: res_bytes = {data_byte, 24'd0};
              endcase
            end else begin
              n_res = 3'd0;
            end
          end
          held_next    = {hd[15:0], data_byte};
          ttl_idx_next = ti + 2'd1;
        end
      end
      dats_pkg::PH_RDHI: begin
        len_hi_next = data_byte;
        phase_next  = dats_pkg::PH_RDLO;
      end
      dats_pkg::PH_RDLO: begin
        skip_next = rdlen;
        if (rdlen == 16'd0) begin
          a_left_next = al_dec;
          phase_next  = (ql != 16'd0 || al_dec != 16'd0) ? dats_pkg::PH_NAME
                                                         : dats_pkg::PH_PASS;
        end else begin
          phase_next = dats_pkg::PH_RDATA;
        end
      end
      dats_pkg::PH_RDATA: begin
        skip_next = sk_dec;
        if (sk_dec == 16'd0) begin
          a_left_next = al_dec;
          phase_next  = (ql != 16'd0 || al_dec != 16'd0) ? dats_pkg::PH_NAME
                                                         : dats_pkg::PH_PASS;
        end
      end
      default: ;
    endcase

    at_start_next = msg_last;
  end

  // parser state: advance on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= dats_pkg::PH_HDR;
      hdr_idx  <= 4'd0;
      q_left   <= 16'd0;
      a_left   <= 16'd0;
      skip     <= 16'd0;
      held     <= 24'd0;
      ttl_idx  <= 2'd0;
      len_hi   <= 8'd0;
      run_min  <= '1;
      mode     <= 1'b0;
      dlt      <= 32'd0;
      at_start <= 1'b1;
    end else if (accept) begin
      phase    <= phase_next;
      hdr_idx  <= hdr_idx_next;
      q_left   <= q_left_next;
      a_left   <= a_left_next;
      skip     <= skip_next;
      held     <= held_next;
      ttl_idx  <= ttl_idx_next;
      len_hi   <= len_hi_next;
      run_min  <= run_min_next;
      mode     <= mode_next;
      dlt      <= dlt_next;
      at_start <= at_start_next;
    end
  end

  // output buffer: load a group, drop one beat per take
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (accept && n_res != 3'd0) begin
      cnt <= n_res;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 3'd0) begin
      obuf      <= res_bytes;
      grp_min   <= run_min_next;
      grp_end   <= msg_last;
      grp_trunc <= msg_last && (phase_next != dats_pkg::PH_PASS);
    end else if (pop) begin
      obuf <= {obuf[23:0], 8'd0};
    end
  end

endmodule

// ----- bench/ttl_scan_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_scan_checker
// Watches both channels of the DNS answer TTL scanner, predicts the output
// beats of every accepted byte and compares them in order with what leaves
// the block. Hands the mismatch count and the number of beats still due to
// the testbench top.
// ----------------------------------------------------------------------------
module ttl_scan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        msg_last,
  input  logic        func,
  input  logic [31:0] delta,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        run_last,
  input  logic        msg_end,
  input  logic [31:0] min_ttl,
  input  logic        truncated,
  output int unsigned mismatches,
  output int unsigned beats_due
);

  typedef struct packed {
    logic [7:0]  octet;
    logic        run_last;
    logic        msg_end;
    logic [31:0] min_ttl;
    logic        truncated;
  } beat_t;

  beat_t       beats_q[$];
  beat_t       got;
  beat_t       want;
  int unsigned err_cnt;

  dats_pkg::phase_t ph;
  logic [3:0]  hdr_idx;
  logic [15:0] q_left;
  logic [15:0] a_left;
  logic [15:0] skip;
  logic [23:0] held;
  logic [1:0]  ttl_idx;
  logic [7:0]  len_hi;
  logic [31:0] min_run;
  logic        mode;
  logic [31:0] dlt;
  logic        fresh;

  function automatic beat_t mk_beat(input logic [7:0] b);
    mk_beat = '{b, 1'b0, 1'b0, min_run, 1'b0};
  endfunction

  function automatic dats_pkg::phase_t next_phase();
    next_phase = (q_left != 0 || a_left != 0) ? dats_pkg::PH_NAME : dats_pkg::PH_PASS;
  endfunction

  task automatic clear_parser();
    ph      = dats_pkg::PH_HDR;
    hdr_idx = '0;
    q_left  = '0;
    a_left  = '0;
    skip    = '0;
    held    = '0;
    ttl_idx = '0;
    len_hi  = '0;
    min_run = '1;
    mode    = 1'b0;
    dlt     = '0;
    fresh   = 1'b1;
  endtask

  task automatic predict_beats(input logic [7:0] b, input logic last, input logic fn,
                               input logic [31:0] d);
    beat_t       res [4];
    int          n;
    int          k;
    logic [31:0] ttl;
    logic [31:0] nv;
    logic [23:0] sh;
    n = 0;
    if (fresh) begin
      clear_parser();
      mode  = fn;
      dlt   = d;
      fresh = 1'b0;
    end
    case (ph)
      dats_pkg::PH_HDR: begin
        if (hdr_idx == dats_pkg::HdrQdHi) q_left[15:8] = b;
        else if (hdr_idx == dats_pkg::HdrQdLo) q_left[7:0] = b;
        else if (hdr_idx == dats_pkg::HdrAnHi) a_left[15:8] = b;
        else if (hdr_idx == dats_pkg::HdrAnLo) a_left[7:0] = b;
        res[n] = mk_beat(b); n++;
        hdr_idx = hdr_idx + 4'd1;
        if (hdr_idx >= dats_pkg::HeaderLen) ph = next_phase();
      end
      dats_pkg::PH_NAME: begin
        res[n] = mk_beat(b); n++;
        if (b == 8'd0) begin
          skip = dats_pkg::FixedQ;
          ph   = dats_pkg::PH_FIXED;
        end else if (b >= dats_pkg::PtrMark) begin
          skip = dats_pkg::FixedPtr;
          ph   = dats_pkg::PH_FIXED;
        end else begin
          skip = {8'd0, b};
          ph   = dats_pkg::PH_LABEL;
        end
      end
      dats_pkg::PH_LABEL: begin
        res[n] = mk_beat(b); n++;
        skip = skip - 16'd1;
        if (skip == 0) ph = dats_pkg::PH_NAME;
      end
      dats_pkg::PH_FIXED: begin
        res[n] = mk_beat(b); n++;
        skip = skip - 16'd1;
        if (skip == 0) begin
          if (q_left != 0) begin
            q_left = q_left - 16'd1;
            ph     = next_phase();
          end else begin
            ttl_idx = '0;
            held    = '0;
            ph      = dats_pkg::PH_TTL;
          end
        end
      end
      dats_pkg::PH_TTL: begin
        if (ttl_idx == 2'd3) begin
          ttl = {held, b};
          if (mode) begin
            nv = ttl - dlt;
            res[n] = mk_beat(nv[31:24]); n++;
            res[n] = mk_beat(nv[23:16]); n++;
            res[n] = mk_beat(nv[15:8]);  n++;
            res[n] = mk_beat(nv[7:0]);   n++;
          end else begin
            if (ttl < min_run) min_run = ttl;
            res[n] = mk_beat(b); n++;
          end
          ttl_idx = '0;
          ph      = dats_pkg::PH_RDHI;
        end else begin
          if (mode) begin
            if (last) begin
              // release the held bytes, then this one
              for (k = 0; k < ttl_idx; k++) begin
                sh = held >> (8 * (ttl_idx - 1 - k));
                res[n] = mk_beat(sh[7:0]); n++;
              end
              res[n] = mk_beat(b); n++;
            end
          end else begin
            res[n] = mk_beat(b); n++;
          end
          held    = {held[15:0], b};
          ttl_idx = ttl_idx + 2'd1;
        end
      end
      dats_pkg::PH_RDHI: begin
        res[n] = mk_beat(b); n++;
        len_hi = b;
        ph     = dats_pkg::PH_RDLO;
      end
      dats_pkg::PH_RDLO: begin
        res[n] = mk_beat(b); n++;
        skip = {len_hi, b};
        if (skip == 0) begin
          a_left = a_left - 16'd1;
          ph     = next_phase();
        end else begin
          ph = dats_pkg::PH_RDATA;
        end
      end
      dats_pkg::PH_RDATA: begin
        res[n] = mk_beat(b); n++;
        skip = skip - 16'd1;
        if (skip == 0) begin
          a_left = a_left - 16'd1;
          ph     = next_phase();
        end
      end
      default: begin
        res[n] = mk_beat(b); n++;
      end
    endcase
    if (n > 0) begin
      res[n-1].run_last = 1'b1;
      if (last) begin
        res[n-1].msg_end   = 1'b1;
        res[n-1].min_ttl   = min_run;
        res[n-1].truncated = (ph != dats_pkg::PH_PASS);
      end
    end
    for (k = 0; k < n; k++) beats_q.push_back(res[k]);
    if (last) fresh = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      beats_q.delete();
      clear_parser();
      err_cnt = 0;
    end else begin
      if (in_valid && in_ready) predict_beats(data_byte, msg_last, func, delta);
      if (out_valid && out_ready) begin
        got = '{out_byte, run_last, msg_end, min_ttl, truncated};
        if (beats_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected beat byte %02h run %b end %b min %08h trunc %b",
                     $realtime, got.octet, got.run_last, got.msg_end, got.min_ttl,
                     got.truncated);
        end else begin
          want = beats_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: exp byte %02h run %b end %b min %08h trunc %b, ",
                        "got byte %02h run %b end %b min %08h trunc %b"},
                       $realtime, want.octet, want.run_last, want.msg_end, want.min_ttl,
                       want.truncated, got.octet, got.run_last, got.msg_end,
                       got.min_ttl, got.truncated);
          end
        end
      end
    end
    mismatches <= err_cnt;
    beats_due  <= beats_q.size();
  end

endmodule

// ----- bench/tb_dns_answer_ttl_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_answer_ttl_scanner
// Feeds the DNS answer TTL scanner with short directed messages and then
// random messages built from headers, questions and answers, some cut short
// and some with corrupted counts, under changing idle and stall patterns.
// The checker beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_dns_answer_ttl_scanner;

  localparam int unsigned RandItems  = 85;
  localparam int unsigned CycleLimit = 200000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        msg_last;
  logic        func;
  logic [31:0] delta;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        msg_end;
  logic [31:0] min_ttl;
  logic        truncated;

  int unsigned mismatches;
  int unsigned beats_due;

  int unsigned send_idle_pct;
  int unsigned rx_stall_pct;
  logic        hold_go;
  logic        hold_rx;
  int unsigned cycles;

  logic [7:0]  msg_q[$];
  int unsigned sent_bytes;
  int unsigned msg_cnt;
  int unsigned rewrite_cnt;
  int unsigned cut_cnt;

  dns_answer_ttl_scanner uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .msg_last(msg_last), .func(func), .delta(delta),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .run_last(run_last), .msg_end(msg_end),
    .min_ttl(min_ttl), .truncated(truncated)
  );

  ttl_scan_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .msg_last(msg_last), .func(func), .delta(delta),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .run_last(run_last), .msg_end(msg_end),
    .min_ttl(min_ttl), .truncated(truncated),
    .mismatches(mismatches), .beats_due(beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long output hold-off while the sender keeps offering beats
  initial begin
    hold_rx <= 1'b0;
    wait (hold_go === 1'b1);
    repeat (3) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (48) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic push_byte(input logic [7:0] b, input logic last, input logic fn,
                           input logic [31:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    msg_last  <= last;
    func      <= fn;
    delta     <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_message(input logic rand_fields, input logic fn,
                              input logic [31:0] d);
    int          k;
    logic        f;
    logic [31:0] dv;
    for (k = 0; k < msg_q.size(); k++) begin
      f  = fn;
      dv = d;
      if (rand_fields) begin
        f = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0:       dv = '0;
          1:       dv = '1;
          default: dv = $urandom();
        endcase
      end
      if (k == 0 && f) rewrite_cnt++;
      push_byte(msg_q[k], k == msg_q.size() - 1, f, dv);
      sent_bytes++;
    end
    msg_cnt++;
  endtask

  task automatic add_record(input logic is_answer);
    int unsigned labels;
    int unsigned ln;
    int unsigned k;
    int unsigned j;
    labels = $urandom_range(0, 2);
    for (k = 0; k < labels; k++) begin
      ln = $urandom_range(1, 3);
      msg_q.push_back(ln[7:0]);
      for (j = 0; j < ln; j++) msg_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      msg_q.push_back(8'($urandom_range(128, 255)));
      msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      msg_q.push_back(8'd0);
    end
    repeat (4) msg_q.push_back(8'($urandom_range(0, 255)));
    if (is_answer) begin
      repeat (4) msg_q.push_back(8'($urandom_range(0, 255)));
      ln = $urandom_range(0, 3);
      msg_q.push_back(8'd0);
      msg_q.push_back(ln[7:0]);
      for (j = 0; j < ln; j++) msg_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_message();
    int unsigned nq;
    int unsigned na;
    int unsigned k;
    int unsigned cut;
    msg_q.delete();
    nq = $urandom_range(0, 1);
    na = $urandom_range(0, 2);
    for (k = 0; k < 12; k++) msg_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) != 0) begin
      msg_q[4] = 8'd0;
      msg_q[5] = nq[7:0];
      msg_q[6] = 8'd0;
      msg_q[7] = na[7:0];
    end
    for (k = 0; k < nq; k++) add_record(1'b0);
    for (k = 0; k < na; k++) add_record(1'b1);
    repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
      cut_cnt++;
    end
  endtask

  initial begin
    logic [191:0] answer_msg;
    int           k;
    int unsigned  phase;
    int unsigned  last_phase;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    data_byte     <= '0;
    msg_last      <= 1'b0;
    func          <= 1'b0;
    delta         <= '0;
    hold_go       <= 1'b0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    sent_bytes    = 0;
    msg_cnt       = 0;
    rewrite_cnt   = 0;
    cut_cnt       = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte message: header cut short
    msg_q.delete();
    msg_q.push_back(8'hFF);
    cut_cnt++;
    send_message(1'b0, 1'b0, 32'h0000_0000);

    // one answer behind a pointer name, TTL rewritten with a wrapping delta
    answer_msg = 192'h00FF8180_00000001_00000000_8000_00010001_00000005_0000;
    msg_q.delete();
    for (k = 23; k >= 0; k--) msg_q.push_back(answer_msg[k*8 +: 8]);
    send_message(1'b0, 1'b1, 32'hFFFF_FFFF);

    hold_go    <= 1'b1;
    last_phase = 0;
    while (sent_bytes < RandItems + 25) begin
      phase = ((sent_bytes - 25) * 4) / RandItems;
      if (phase > 3) phase = 3;
      if (phase != last_phase) begin
        // drain before changing the traffic pattern
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0) @(posedge clk);
        last_phase = phase;
      end
      case (phase)
        0:       begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; rx_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin send_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      build_message();
      send_message(1'b1, 1'b0, 32'h0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d messages: %0d rewriting TTLs, %0d cut short.",
             sent_bytes, msg_cnt, rewrite_cnt, cut_cnt);
    $display("Traffic ran free, with input gaps, with output stalls and with both.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
